[rtl/core/vps_pkg.sv]
package vps_pkg;

    // Number of pot readings summed per round; a round is SAMPLES + 1 sample ticks.
    localparam int SAMPLES = 5;

    localparam int SMP_W = 12;
    localparam int SUM_W = $clog2(SAMPLES * 4095 + 1);
    localparam int PHASE_W = $clog2(SAMPLES + 1);

    // The mean is taken as (sum * DIV_MUL) >> DIV_SH, exact over the whole sum range.
    localparam int DIV_SH = SUM_W + $clog2(SAMPLES);
    localparam longint DIV_MUL = ((64'd1 << DIV_SH) + SAMPLES - 1) / SAMPLES;
    localparam int MUL_W = $clog2(DIV_MUL + 1);
    localparam int PROD_W = SUM_W + MUL_W;

    localparam logic [SMP_W-1:0] POT_FULL = 12'd4095;
    localparam logic [SMP_W-1:0] POT_REV_HIGH = 12'd4000;

    localparam logic [11:0] FRONT_OPEN_RST = 12'd3800;
    localparam logic [11:0] REVERSE_OPEN_RST = 12'd1560;
    localparam logic [11:0] CLOSE_POS_RST = 12'd2730;
    localparam logic [7:0] OPEN_WINDOW_RST = 8'd40;
    localparam logic [7:0] CLOSE_WINDOW_RST = 8'd20;
    localparam logic [15:0] SETTLE_LIMIT_RST = 16'd226;
    localparam logic [11:0] CAP_MIN_RST = 12'd1200;
    localparam logic [11:0] FRONT_REGION_RST = 12'd2600;

    localparam int ADDR_W = 5;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_FRONT_OPEN = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_REVERSE_OPEN = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CLOSE_POS = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OPEN_WINDOW = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CLOSE_WINDOW = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SETTLE_LIMIT = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CAP_MIN = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_FRONT_REGION = 3'd7;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_OPEN = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;

    typedef enum logic [1:0] {
        TGT_STOP = 2'd0,
        TGT_FRONT = 2'd1,
        TGT_REVERSE = 2'd2,
        TGT_CLOSE = 2'd3
    } target_t;

    typedef enum logic [1:0] {
        DRV_STOP = 2'd0,
        DRV_RAISE = 2'd1,
        DRV_LOWER = 2'd2
    } drive_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [11:0] pot_sample;
        logic [11:0] cap_sample;
        logic hand_level;
    } in_item_t;

    typedef struct packed {
        logic [1:0] drive;
        logic [1:0] target_now;
        logic valve_open;
        logic keys_enabled;
        logic arrived;
    } out_item_t;

endpackage

[rtl/core/valve_position_servo.sv]
// Valve position servo.
// Input channel (in_valid, in_stall, in_data): one transfer per command or ADC sample tick.
// Output channel (out_valid, out_stall, out_data): exactly one result per input transfer,
// in order, showing drive, target, valve state, key enable and the arrival flag.
// Configuration registers sit on the APB port at byte address 4 * index; the user must
// write them only while the block is idle, as the block itself does not enforce this.
// pready is always high and reads return the value.
// An item is captured in the input register at its transfer, and its result is loaded
// into the output register when that register is free.
// Throughput: one item per cycle unless the receiver stalls. The single pass from the input
// register to the output register holds the sum-and-scale of the round mean (one constant
// multiplier) and, for the last tick of a round, the squared deviation (one 12x12 multiplier).
// When the receiver stalls, the output register holds its result; one more item may wait
// in the input register, after which in_stall is raised until the output moves.
// Reset clears both stages, loads the default positions and windows, and leaves the motor
// stopped, the valve marked closed, keys enabled and the lever resume armed.
module valve_position_servo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  vps_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output vps_pkg::out_item_t                out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vps_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import vps_pkg::*;

    logic [11:0] front_open_pos_reg;
    logic [11:0] reverse_open_pos_reg;
    logic [11:0] close_pos_reg;
    logic [7:0] open_window_reg;
    logic [7:0] close_window_reg;
    logic [15:0] settle_limit_reg;
    logic [11:0] cap_min_reg;
    logic [11:0] front_region_low_reg;

    logic [REG_IDX_W-1:0] reg_idx;
    logic cfg_write;

    logic in_valid_reg;
    in_item_t in_item_reg;
    logic out_valid_reg;
    out_item_t out_item_reg;
    logic fire;

    target_t target_reg, target_next;
    target_t lever_target_reg, lever_target_next;
    logic resume_armed_reg, resume_armed_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [SMP_W-1:0] mean_reg, mean_next;
    drive_t drive_reg, drive_next;
    logic valve_open_reg, valve_open_next;
    logic keys_on_reg, keys_on_next;
    logic arrived_next;

    logic [SMP_W-1:0] pot;
    logic cap_ok;
    logic front_region;
    target_t open_target;
    drive_t open_drive;
    drive_t close_drive;
    logic [SUM_W-1:0] sum_base;
    logic [SUM_W-1:0] sum_after;
    logic [PROD_W-1:0] mean_prod;
    logic [SMP_W-1:0] dev_mag;
    logic [2*SMP_W-1:0] dev_sq;
    logic still;
    logic window_hit;
    logic hit_opened;

    function automatic logic in_win(input logic [11:0] p, input logic [11:0] c,
                                    input logic [7:0] h);
        return ({1'b0, p} + 13'(h) >= {1'b0, c}) && ({1'b0, p} <= {1'b0, c} + 13'(h));
    endfunction

    // Configuration port.
    assign pready = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (reg_idx)
            REG_FRONT_OPEN:   prdata = {20'd0, front_open_pos_reg};
            REG_REVERSE_OPEN: prdata = {20'd0, reverse_open_pos_reg};
            REG_CLOSE_POS:    prdata = {20'd0, close_pos_reg};
            REG_OPEN_WINDOW:  prdata = {24'd0, open_window_reg};
            REG_CLOSE_WINDOW: prdata = {24'd0, close_window_reg};
            REG_SETTLE_LIMIT: prdata = {16'd0, settle_limit_reg};
            REG_CAP_MIN:      prdata = {20'd0, cap_min_reg};
            REG_FRONT_REGION: prdata = {20'd0, front_region_low_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_open_pos_reg <= FRONT_OPEN_RST;
            reverse_open_pos_reg <= REVERSE_OPEN_RST;
            close_pos_reg <= CLOSE_POS_RST;
            open_window_reg <= OPEN_WINDOW_RST;
            close_window_reg <= CLOSE_WINDOW_RST;
            settle_limit_reg <= SETTLE_LIMIT_RST;
            cap_min_reg <= CAP_MIN_RST;
            front_region_low_reg <= FRONT_REGION_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_FRONT_OPEN:   front_open_pos_reg <= pwdata[11:0];
                REG_REVERSE_OPEN: reverse_open_pos_reg <= pwdata[11:0];
                REG_CLOSE_POS:    close_pos_reg <= pwdata[11:0];
                REG_OPEN_WINDOW:  open_window_reg <= pwdata[7:0];
                REG_CLOSE_WINDOW: close_window_reg <= pwdata[7:0];
                REG_SETTLE_LIMIT: settle_limit_reg <= pwdata[15:0];
                REG_CAP_MIN:      cap_min_reg <= pwdata[11:0];
                REG_FRONT_REGION: front_region_low_reg <= pwdata[11:0];
                default:          ;
            endcase
        end
    end

    // Handshake: the input register moves into the output register whenever that is free.
    assign fire = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign out_valid = out_valid_reg;
    assign out_data = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_data;
        end
        if (fire)
        begin
            out_item_reg <= '{drive: drive_next, target_now: target_next,
                              valve_open: valve_open_next, keys_enabled: keys_on_next,
                              arrived: arrived_next};
        end
    end

    // Shared terms of the single pass.
    assign pot = in_item_reg.pot_sample;
    assign cap_ok = in_item_reg.cap_sample > cap_min_reg;
    assign front_region = (pot > front_region_low_reg) && (pot < POT_FULL);
    assign open_target = front_region ? TGT_FRONT : TGT_REVERSE;
    assign close_drive = (pot > close_pos_reg) ? DRV_LOWER : DRV_RAISE;

    always_comb
    begin
        if (front_region)
        begin
            open_drive = (pot < front_open_pos_reg) ? DRV_RAISE : DRV_LOWER;
        end
        else
        begin
            open_drive = (pot < reverse_open_pos_reg || pot > POT_REV_HIGH) ? DRV_RAISE
                                                                             : DRV_LOWER;
        end
    end

    // The sum restarts at the first tick of a round; the mean is latched at the last summed tick.
    assign sum_base = (phase_reg == '0) ? '0 : sum_reg;
    assign sum_after = sum_base + SUM_W'(pot);
    assign mean_prod = PROD_W'(sum_after) * PROD_W'(DIV_MUL);
    assign dev_mag = (pot >= mean_reg) ? pot - mean_reg : mean_reg - pot;
    assign dev_sq = (2*SMP_W)'(dev_mag) * (2*SMP_W)'(dev_mag);
    assign still = dev_sq < (2*SMP_W)'(settle_limit_reg);

    always_comb
    begin
        case (target_reg)
            TGT_FRONT:
            begin
                window_hit = in_win(pot, front_open_pos_reg, open_window_reg);
                hit_opened = 1'b1;
            end
            TGT_REVERSE:
            begin
                window_hit = in_win(pot, reverse_open_pos_reg, open_window_reg);
                hit_opened = 1'b1;
            end
            default:
            begin
                window_hit = in_win(pot, close_pos_reg, close_window_reg);
                hit_opened = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        target_next = target_reg;
        lever_target_next = lever_target_reg;
        resume_armed_next = resume_armed_reg;
        sum_next = sum_reg;
        phase_next = phase_reg;
        mean_next = mean_reg;
        drive_next = drive_reg;
        valve_open_next = valve_open_reg;
        keys_on_next = keys_on_reg;
        arrived_next = 1'b0;

        case (in_item_reg.cmd)
            CMD_OPEN:
            begin
                if (cap_ok)
                begin
                    target_next = open_target;
                    lever_target_next = open_target;
                    drive_next = open_drive;
                end
            end
            CMD_CLOSE:
            begin
                if (cap_ok)
                begin
                    target_next = TGT_CLOSE;
                    lever_target_next = TGT_CLOSE;
                    drive_next = close_drive;
                end
            end
            CMD_SAMPLE:
            begin
                if (phase_reg == '0)
                begin
                    if (!in_item_reg.hand_level)
                    begin
                        target_next = lever_target_reg;
                        resume_armed_next = 1'b1;
                        drive_next = DRV_STOP;
                        keys_on_next = 1'b0;
                    end
                    else if (cap_ok && resume_armed_reg)
                    begin
                        resume_armed_next = 1'b0;
                        keys_on_next = 1'b1;
                        case (target_reg)
                            TGT_CLOSE:
                            begin
                                target_next = TGT_CLOSE;
                                lever_target_next = TGT_CLOSE;
                                drive_next = close_drive;
                            end
                            TGT_FRONT, TGT_REVERSE:
                            begin
                                target_next = open_target;
                                lever_target_next = open_target;
                                drive_next = open_drive;
                            end
                            default:
                            begin
                                drive_next = DRV_STOP;
                            end
                        endcase
                    end
                end
                if (phase_reg < PHASE_W'(SAMPLES))
                begin
                    sum_next = sum_after;
                    phase_next = phase_reg + 1'b1;
                    if (phase_reg == PHASE_W'(SAMPLES - 1))
                    begin
                        mean_next = mean_prod[DIV_SH +: SMP_W];
                    end
                end
                else
                begin
                    // Last tick of a round: stop only when steady and inside the window.
                    if (still && target_reg != TGT_STOP && window_hit)
                    begin
                        drive_next = DRV_STOP;
                        target_next = TGT_STOP;
                        valve_open_next = hit_opened;
                        arrived_next = 1'b1;
                    end
                    phase_next = '0;
                    sum_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TGT_STOP;
            lever_target_reg <= TGT_CLOSE;
            resume_armed_reg <= 1'b1;
            sum_reg <= '0;
            phase_reg <= '0;
            mean_reg <= '0;
            drive_reg <= DRV_STOP;
            valve_open_reg <= 1'b0;
            keys_on_reg <= 1'b1;
        end
        else if (fire)
        begin
            target_reg <= target_next;
            lever_target_reg <= lever_target_next;
            resume_armed_reg <= resume_armed_next;
            sum_reg <= sum_next;
            phase_reg <= phase_next;
            mean_reg <= mean_next;
            drive_reg <= drive_next;
            valve_open_reg <= valve_open_next;
            keys_on_reg <= keys_on_next;
        end
    end

endmodule

[rtl/core/vps_checker.sv]
module vps_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_stall,
    input  vps_pkg::out_item_t  out_data,
    input  logic                pready
);
    import vps_pkg::*;

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // Arrival always leaves the motor stopped with no target.
    a_arrive_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.arrived |->
            out_data.drive == DRV_STOP && out_data.target_now == TGT_STOP)
        else $error("arrival without stopping");

    // The motor is only driven toward a real target.
    a_no_target_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.target_now == TGT_STOP |-> out_data.drive == DRV_STOP)
        else $error("motor driven with no target");

    // Only stop, raise and lower are ever driven.
    a_drive_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.drive[1] && out_data.drive[0]))
        else $error("unknown drive code");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("configuration port not ready");

endmodule

bind valve_position_servo vps_checker u_vps_checker (.*);
